// ----- src/swcrl_pkg.sv -----
// Package for the sliding-window click rate limiter.
// Holds sizing constants, event codes and the sequencer state type.
// No dependencies.
`default_nettype none

package swcrl_pkg;

  localparam int USERS            = 16;
  localparam int STORE_DEPTH      = 128;
  localparam int WINDOW_MS        = 1000;
  localparam int DEDUP_MS         = 50;
  localparam int SUSPICIOUS_LEVEL = 30;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 32;
  localparam int LIMIT_W  = 7;
  localparam int COUNT_W  = 8;

  localparam int UIDX_W   = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int PTR_W    = $clog2(STORE_DEPTH);
  localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W   = $clog2(USERS * STORE_DEPTH);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(15);

  localparam logic [FUNC_W-1:0] FUNC_CLICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ATTACK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_CHK    = 5'b00100,
    S_APPEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- src/sliding_window_click_rate_limiter.sv -----
// Top level of the sliding-window click rate limiter.
// Holds the sequencer, the stamp RAM and the per-user slot registers.
// Depends on swcrl_pkg.
`default_nettype none

// One transaction in, one result out. Clear events, ignored codes and attacks
// that fall within the dedup span of the last click go from deciding straight
// to hand-over. A counted event is decided, then walks the stored timestamps
// of its slot and retires the stale ones, appends its own stamp and is handed
// over; the walk is skipped on an empty slot and stops at the first timestamp
// still inside the window or when it empties the slot. The walk goes through
// the single read port of the stamp RAM (at most STORE_DEPTH, 128, stamps per
// event). The next transaction is accepted once the sequencer is back in idle,
// after the previous result has been written to the output register; that
// register holds the result while the sink stalls.
// rate_limit may be written whenever no transaction is in flight.
module sliding_window_click_rate_limiter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [swcrl_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [swcrl_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [swcrl_pkg::SLOT_W-1:0]      user_slot_i,
  input  wire logic [swcrl_pkg::TIME_W-1:0]      time_ms_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   blocked_o,
  output logic                                   suspicious_o,
  output logic [swcrl_pkg::COUNT_W-1:0]          attempt_count_o
);

  localparam int UIDX_W = swcrl_pkg::UIDX_W;
  localparam int PTR_W  = swcrl_pkg::PTR_W;
  localparam int CNT_W  = swcrl_pkg::CNT_W;
  localparam int ADDR_W = swcrl_pkg::ADDR_W;
  localparam int TIME_W = swcrl_pkg::TIME_W;
  localparam int MEM_DEPTH = swcrl_pkg::USERS * swcrl_pkg::STORE_DEPTH;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(swcrl_pkg::STORE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [UIDX_W-1:0] u,
                                                 input logic [PTR_W-1:0]  p);
    return ADDR_W'(u) * ADDR_W'(swcrl_pkg::STORE_DEPTH) + ADDR_W'(p);
  endfunction

  swcrl_pkg::state_e state_q, state_d;

  logic [swcrl_pkg::LIMIT_W-1:0] rate_limit_q;

  logic [swcrl_pkg::FUNC_W-1:0] func_q;
  logic [swcrl_pkg::SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0]            time_q;

  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic                         res_blk_q, res_blk_d;
  logic                         res_flag_q, res_flag_d;
  logic [swcrl_pkg::COUNT_W-1:0] res_cnt_q, res_cnt_d;

  logic                          out_valid_q;
  logic                          out_blk_q;
  logic                          out_flag_q;
  logic [swcrl_pkg::COUNT_W-1:0] out_cnt_q;

  // per-user slot state
  logic [PTR_W-1:0]  optr_q   [swcrl_pkg::USERS];
  logic [CNT_W-1:0]  hcnt_q   [swcrl_pkg::USERS];
  logic              fvalid_q [swcrl_pkg::USERS];
  logic              cvalid_q [swcrl_pkg::USERS];
  logic              cblk_q   [swcrl_pkg::USERS];
  logic [TIME_W-1:0] lflag_q  [swcrl_pkg::USERS];
  logic [TIME_W-1:0] lclick_q [swcrl_pkg::USERS];

  // stamp RAM
  logic [TIME_W-1:0] stamp_mem [MEM_DEPTH];
  logic [TIME_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  logic [8:0]        slot_ext;
  logic [UIDX_W-1:0] uidx;
  logic              slot_ok;
  logic              dedup_hit;
  logic              count_ev;
  logic              clr_slot;
  logic              out_free;
  logic              in_acc;

  logic [TIME_W-1:0] age;
  logic              full;
  logic [CNT_W:0]    wsum;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  new_ptr;
  logic [CNT_W-1:0]  new_cnt;
  logic [15:0]       n_ext;
  logic              new_flag;
  logic              new_blk;

  assign in_stall_o = (state_q != swcrl_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign slot_ext  = 9'(slot_q);
  assign uidx      = slot_ext[UIDX_W-1:0];
  assign slot_ok   = slot_ext < 9'(swcrl_pkg::USERS);
  assign dedup_hit = cvalid_q[uidx] &&
                     ((time_q - lclick_q[uidx]) <= TIME_W'(swcrl_pkg::DEDUP_MS));
  assign count_ev  = slot_ok && ((func_q == swcrl_pkg::FUNC_CLICK) ||
                     ((func_q == swcrl_pkg::FUNC_ATTACK) && !dedup_hit));
  assign clr_slot  = (state_q == swcrl_pkg::S_DECIDE) && slot_ok &&
                     (func_q == swcrl_pkg::FUNC_CLEAR);

  assign age     = time_q - rdata_q;
  assign full    = (cnt_q == CNT_W'(swcrl_pkg::STORE_DEPTH));
  assign wsum    = (CNT_W+1)'(ptr_q) + (CNT_W+1)'(cnt_q);
  assign wr_ptr  = full ? ptr_q :
                   (wsum >= (CNT_W+1)'(swcrl_pkg::STORE_DEPTH)) ?
                   PTR_W'(wsum - (CNT_W+1)'(swcrl_pkg::STORE_DEPTH)) : PTR_W'(wsum);
  assign new_ptr = full ? ptr_inc(ptr_q) : ptr_q;
  assign new_cnt = full ? cnt_q : cnt_q + CNT_W'(1);
  assign n_ext   = 16'(new_cnt);
  assign new_flag = (n_ext >= 16'(swcrl_pkg::SUSPICIOUS_LEVEL)) &&
                    (!fvalid_q[uidx] ||
                     ((time_q - lflag_q[uidx]) >= TIME_W'(swcrl_pkg::WINDOW_MS)));
  assign new_blk  = !((rate_limit_q != '0) && (n_ext <= 16'(rate_limit_q)));

  assign wr_en   = (state_q == swcrl_pkg::S_APPEND);
  assign wr_addr = mem_addr(uidx, wr_ptr);
  assign rd_addr = mem_addr(uidx, ptr_d);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    res_blk_d  = res_blk_q;
    res_flag_d = res_flag_q;
    res_cnt_d  = res_cnt_q;
    case (state_q)
      swcrl_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = swcrl_pkg::S_DECIDE;
        end
      end
      swcrl_pkg::S_DECIDE: begin
        res_blk_d  = 1'b0;
        res_flag_d = 1'b0;
        res_cnt_d  = '0;
        if (count_ev) begin
          ptr_d = optr_q[uidx];
          cnt_d = hcnt_q[uidx];
          state_d = (hcnt_q[uidx] != '0) ? swcrl_pkg::S_CHK : swcrl_pkg::S_APPEND;
        end else begin
          if (slot_ok && (func_q == swcrl_pkg::FUNC_ATTACK)) begin
            res_blk_d = cblk_q[uidx];
          end
          state_d = swcrl_pkg::S_DONE;
        end
      end
      swcrl_pkg::S_CHK: begin
        if (age >= TIME_W'(swcrl_pkg::WINDOW_MS)) begin
          ptr_d = ptr_inc(ptr_q);
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = swcrl_pkg::S_APPEND;
          end
        end else begin
          state_d = swcrl_pkg::S_APPEND;
        end
      end
      swcrl_pkg::S_APPEND: begin
        ptr_d      = new_ptr;
        cnt_d      = new_cnt;
        res_blk_d  = new_blk;
        res_flag_d = new_flag;
        res_cnt_d  = (n_ext > 16'd255) ? 8'hFF : n_ext[7:0];
        state_d    = swcrl_pkg::S_DONE;
      end
      swcrl_pkg::S_DONE: begin
        if (out_free) begin
          state_d = swcrl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = swcrl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swcrl_pkg::S_IDLE;
      rate_limit_q <= swcrl_pkg::LIMIT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rate_limit_q <= cfg_wdata_i;
      end
      if ((state_q == swcrl_pkg::S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      slot_q <= user_slot_i;
      time_q <= time_ms_i;
    end
    ptr_q      <= ptr_d;
    cnt_q      <= cnt_d;
    res_blk_q  <= res_blk_d;
    res_flag_q <= res_flag_d;
    res_cnt_q  <= res_cnt_d;
    if ((state_q == swcrl_pkg::S_DONE) && out_free) begin
      out_blk_q  <= res_blk_q;
      out_flag_q <= res_flag_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < swcrl_pkg::USERS; i++) begin
        optr_q[i]   <= '0;
        hcnt_q[i]   <= '0;
        fvalid_q[i] <= 1'b0;
        cvalid_q[i] <= 1'b0;
        cblk_q[i]   <= 1'b0;
      end
    end else if (clr_slot) begin
      optr_q[uidx]   <= '0;
      hcnt_q[uidx]   <= '0;
      fvalid_q[uidx] <= 1'b0;
      cvalid_q[uidx] <= 1'b0;
      cblk_q[uidx]   <= 1'b0;
    end else if (state_q == swcrl_pkg::S_APPEND) begin
      optr_q[uidx] <= new_ptr;
      hcnt_q[uidx] <= new_cnt;
      if (new_flag) begin
        fvalid_q[uidx] <= 1'b1;
      end
      if (func_q == swcrl_pkg::FUNC_CLICK) begin
        cvalid_q[uidx] <= 1'b1;
        cblk_q[uidx]   <= new_blk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == swcrl_pkg::S_APPEND) begin
      if (new_flag) begin
        lflag_q[uidx] <= time_q;
      end
      if (func_q == swcrl_pkg::FUNC_CLICK) begin
        lclick_q[uidx] <= time_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= time_q;
    end
    rdata_q <= stamp_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign blocked_o       = out_blk_q;
  assign suspicious_o    = out_flag_q;
  assign attempt_count_o = out_cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swcrl_pkg::S_CHK) |-> (cnt_q != '0 &&
      cnt_q <= CNT_W'(swcrl_pkg::STORE_DEPTH)))
    else $error("retire walk with empty or oversized count");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == swcrl_pkg::S_DONE))
    else $error("result appeared without a finished transaction");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swcrl_pkg::S_DONE && out_valid_q && out_stall_i) |=>
      (state_q == swcrl_pkg::S_DONE))
    else $error("sequencer left done while output was still held");
`endif

endmodule

`default_nettype wire
